// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: operation and status
// codes, field widths and the layout of one stored entry.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DATA_W   = 32;
   localparam int PRIO_W   = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // Operation codes carried on the request channel.
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Status codes returned with every result.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

   // One stored entry: data word and its signed priority.
   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

endpackage

// ===== sv/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels of the sorted priority queue. A transfer happens at a
// rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface spq_req_if;
   import spq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic signed [DATA_W-1:0] item_data;
   logic signed [PRIO_W-1:0] item_priority;

   modport source (output valid, output operation, output item_data,
                   output item_priority, input ready);
   modport sink   (input valid, input operation, input item_data,
                   input item_priority, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] removed_data;
   logic [STATUS_W-1:0]      status;
   logic [COUNT_W-1:0]       entry_count;

   modport source (output valid, output removed_data, output status,
                   output entry_count, input ready);
   modport sink   (input valid, input removed_data, input status,
                   input entry_count, output ready);
endinterface

// ===== sv/stable_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded priority queue kept in sorted order in a circular entry memory.
// Lowest priority leaves first; equal priorities leave in arrival order.
//
//   Channel   Direction  Transfer carries
//   req_ch    in         operation, item_data, item_priority
//   rsp_ch    out        removed_data, status, entry_count
//
// An enqueue walks the stored entries from the back, one compare and one
// memory move per cycle, until it finds the slot for the new entry; into an
// empty queue it writes the entry at once, and into a full one it is dropped.
// A dequeue makes one memory read; an empty dequeue makes none.
// The request side is ready only while the sequencer is idle; a finished
// result waits in the output register while the next request is taken.
// Reset is synchronous and empties the queue; the memory is not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue_core #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_ch,
   spq_rsp_if.source  rsp_ch
);
   import spq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = AW + 1;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DEQ   = 3'd1;
   localparam logic [2:0] S_INS   = 3'd2;
   localparam logic [2:0] S_PLACE = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   // Circular pointer steps.
   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      ptr_inc = (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      ptr_dec = (p == '0) ? AW'(CAPACITY - 1) : p - AW'(1);
   endfunction

   logic [2:0]               state_ff, state_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            slot_ff, slot_in;
   logic [AW-1:0]            rd_addr_ff, rd_addr_in;
   logic [CW-1:0]            remain_ff, remain_in;
   entry_type                new_ff, new_in;
   logic signed [DATA_W-1:0] res_data_ff, res_data_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   entry_type                mem [CAPACITY];
   entry_type                mem_rd_ff;
   logic                     mem_we;
   logic [AW-1:0]            mem_wa;
   entry_type                mem_wd;
   logic [AW-1:0]            mem_ra;

   logic                     req_xfer;
   logic                     rsp_free;
   logic [SW-1:0]            tail_sum;
   logic [AW-1:0]            tail;
   entry_type                req_entry;

   // Slot just behind the last stored entry.
   assign tail_sum = SW'(head_ff) + SW'(count_ff);
   assign tail     = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY))
                                                 : AW'(tail_sum);

   assign req_entry.data = req_ch.item_data;
   assign req_entry.prio = req_ch.item_priority;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   // Sequencer: insertion walks backward from the tail, one entry per cycle.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      slot_in       = slot_ff;
      rd_addr_in    = rd_addr_ff;
      remain_in     = remain_ff;
      new_in        = new_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_wa        = slot_ff;
      mem_wd        = new_ff;
      mem_ra        = rd_addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            mem_ra = (req_ch.operation == OP_DEQUEUE) ? head_ff : ptr_dec(tail);
            if (req_xfer) begin
               res_data_in   = '0;
               res_status_in = ST_OK;
               if (req_ch.operation == OP_DEQUEUE) begin
                  if (count_ff == '0) begin
                     res_status_in = ST_UNDERFLOW;
                     state_in      = S_EMIT;
                  end else begin
                     rd_addr_in = head_ff;
                     state_in   = S_DEQ;
                  end
               end else if (count_ff == CW'(CAPACITY)) begin
                  res_status_in = ST_OVERFLOW;
                  state_in      = S_EMIT;
               end else if (count_ff == '0) begin
                  mem_we   = 1'b1;
                  mem_wa   = tail;
                  mem_wd   = req_entry;
                  count_in = count_ff + CW'(1);
                  state_in = S_EMIT;
               end else begin
                  new_in     = req_entry;
                  slot_in    = tail;
                  rd_addr_in = ptr_dec(tail);
                  remain_in  = count_ff;
                  state_in   = S_INS;
               end
            end
         end
         S_DEQ: begin
            res_data_in = mem_rd_ff.data;
            head_in     = ptr_inc(head_ff);
            count_in    = count_ff - CW'(1);
            state_in    = S_EMIT;
         end
         S_INS: begin
            if (mem_rd_ff.prio > new_ff.prio) begin
               // Stored entry leaves later: move it one slot back.
               mem_we  = 1'b1;
               mem_wd  = mem_rd_ff;
               slot_in = rd_addr_ff;
               if (remain_ff == CW'(1)) begin
                  state_in = S_PLACE;
               end else begin
                  rd_addr_in = ptr_dec(rd_addr_ff);
                  mem_ra     = ptr_dec(rd_addr_ff);
                  remain_in  = remain_ff - CW'(1);
               end
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = S_EMIT;
            end
         end
         S_PLACE: begin
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      rd_addr_ff    <= rd_addr_in;
      remain_ff     <= remain_in;
      new_ff        <= new_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.removed_data = rsp_data_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.entry_count  = rsp_count_ff;

   // The stored count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // The count moves by at most one entry per cycle.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> (count_ff == $past(count_ff) + CW'(1)) ||
                             (count_ff == $past(count_ff) - CW'(1)))
      else $error("entry count jumped");

   // During the backward walk the entries left to visit stay within the queue.
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS) |-> (remain_ff != '0) && (remain_ff <= count_ff))
      else $error("insertion walk out of range");

   // A rejected operation never returns data.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_data_ff == '0))
      else $error("rejected operation returned data");

endmodule
